@@ sv/ita_pkg.sv @@
`default_nettype none

package ita_pkg;

  // Format selection codes carried in the action field.
  typedef enum logic [2:0] {
    ACT_SDEC = 3'd0,
    ACT_UDEC = 3'd1,
    ACT_HEXL = 3'd2,
    ACT_HEXU = 3'd3,
    ACT_ADDR = 3'd4
  } ita_action_t;

  // Input transaction payload.
  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] value;
  } ita_in_t;

  // Result transaction payload, one per character.
  typedef struct packed {
    logic [7:0]  out_char;
    logic        last_char;
    logic [31:0] total_written;
  } ita_out_t;

  // Classified job handed from the front part to the back part.
  typedef struct packed {
    logic [63:0] mag;
    logic        neg;
    logic        is_dec;
    logic        upper;
  } ita_job_t;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_LA    = 8'h61;

  // ASCII code of one digit; decimal digits never exceed nine.
  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [7:0] code;
    if (nib < 4'd10) begin
      code = CHAR_ZERO + {4'd0, nib};
    end else if (upper) begin
      code = CHAR_UA + {4'd0, nib} - 8'd10;
    end else begin
      code = CHAR_LA + {4'd0, nib} - 8'd10;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

@@ sv/ita_front.sv @@
`default_nettype none

module ita_front
  import ita_pkg::*;
(
  input  wire logic     in_push,
  input  ita_in_t       in_data,
  output logic          in_full,
  input  wire logic     q_full,
  output logic          q_push,
  output ita_job_t      q_job
);

  logic [31:0] low;
  logic        act_ok;
  logic        sgn_neg;

  assign low = in_data.value[31:0];

  // Only the defined formats produce a job; others are consumed and dropped.
  always_comb begin
    act_ok = (in_data.action == ACT_SDEC) || (in_data.action == ACT_UDEC) ||
             (in_data.action == ACT_HEXL) || (in_data.action == ACT_HEXU) ||
             (in_data.action == ACT_ADDR);
  end

  assign in_full = q_full;
  assign q_push  = in_push && !q_full && act_ok;
  assign sgn_neg = (in_data.action == ACT_SDEC) && low[31];

  // Classify the transaction into magnitude, sign, radix and letter case.
  // The two's complement of the most negative value is itself, read unsigned.
  always_comb begin
    q_job.neg    = sgn_neg;
    q_job.is_dec = (in_data.action == ACT_SDEC) || (in_data.action == ACT_UDEC);
    q_job.upper  = (in_data.action == ACT_HEXU);
    if (in_data.action == ACT_ADDR) begin
      q_job.mag = in_data.value;
    end else if (sgn_neg) begin
      q_job.mag = {32'd0, (~low) + 32'd1};
    end else begin
      q_job.mag = {32'd0, low};
    end
  end

endmodule

`default_nettype wire

@@ sv/ita_queue.sv @@
`default_nettype none

module ita_queue
  import ita_pkg::*;
#(
  parameter int DEPTH = 2
)
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  ita_job_t  push_job,
  output logic      full,
  input  wire logic pop,
  output ita_job_t  head_job,
  output logic      empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ita_job_t        mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]     cnt_r, cnt_nxt;

  assign full     = (cnt_r == (AW + 1)'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_job = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + (AW + 1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

@@ sv/ita_back.sv @@
`default_nettype none

module ita_back
  import ita_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_empty,
  input  ita_job_t  q_job,
  output logic      q_pop,
  input  wire logic out_pop,
  output logic      out_empty,
  output ita_out_t  out_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_EMIT = 4'b1000
  } ita_state_t;

  ita_state_t  state_r, state_nxt;
  logic [63:0] dig_r, dig_nxt;
  logic [39:0] bcd_r, bcd_nxt;
  logic [31:0] sh_r, sh_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic        neg_r, neg_nxt;
  logic        upper_r, upper_nxt;
  logic [31:0] total_r, total_nxt;
  logic        out_valid_r, out_valid_nxt;
  ita_out_t    out_data_r, out_data_nxt;
  logic        fire;
  logic [71:0] dab;

  // Four double-dabble steps: add three to each BCD digit of five or more,
  // then shift one bit of the binary word in.
  function automatic logic [71:0] dabble4(input logic [39:0] bcd, input logic [31:0] sh);
    logic [71:0] w;
    w = {bcd, sh};
    for (int s = 0; s < 4; s++) begin
      for (int d = 0; d < 10; d++) begin
        if (w[32 + 4 * d +: 4] >= 4'd5) begin
          w[32 + 4 * d +: 4] = w[32 + 4 * d +: 4] + 4'd3;
        end
      end
      w = {w[70:0], 1'b0};
    end
    return w;
  endfunction

  // Position of the most significant nonzero digit, zero when all are zero.
  function automatic logic [3:0] top_digit(input logic [63:0] dig);
    logic [3:0] p;
    p = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (dig[4 * i +: 4] != 4'd0) begin
        p = 4'(i);
      end
    end
    return p;
  endfunction

  assign dab       = dabble4(bcd_r, sh_r);
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign fire      = (state_r == ST_EMIT) && (!out_valid_r || out_pop);
  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;

  // Conversion sequencer and character emission.
  always_comb begin
    state_nxt    = state_r;
    dig_nxt      = dig_r;
    bcd_nxt      = bcd_r;
    sh_nxt       = sh_r;
    cnt_nxt      = cnt_r;
    pos_nxt      = pos_r;
    neg_nxt      = neg_r;
    upper_nxt    = upper_r;
    total_nxt    = total_r;
    out_data_nxt = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          neg_nxt   = q_job.neg;
          upper_nxt = q_job.upper;
          if (q_job.is_dec) begin
            sh_nxt    = q_job.mag[31:0];
            bcd_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = ST_CONV;
          end else begin
            dig_nxt   = q_job.mag;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_CONV: begin
        bcd_nxt = dab[71:32];
        sh_nxt  = dab[31:0];
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          dig_nxt   = {24'd0, dab[71:32]};
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        pos_nxt   = top_digit(dig_r);
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (fire) begin
          total_nxt                  = total_r + 32'd1;
          out_data_nxt.total_written = total_r + 32'd1;
          if (neg_r) begin
            out_data_nxt.out_char  = CHAR_MINUS;
            out_data_nxt.last_char = 1'b0;
            neg_nxt                = 1'b0;
          end else begin
            out_data_nxt.out_char  = digit_char(dig_r[{pos_r, 2'b00} +: 4], upper_r);
            out_data_nxt.last_char = (pos_r == 4'd0);
            if (pos_r == 4'd0) begin
              state_nxt = ST_IDLE;
            end else begin
              pos_nxt = pos_r - 4'd1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register holds one character until it is taken.
  always_comb begin
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      neg_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      neg_r       <= neg_nxt;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    dig_r      <= dig_nxt;
    bcd_r      <= bcd_nxt;
    sh_r       <= sh_nxt;
    cnt_r      <= cnt_nxt;
    pos_r      <= pos_nxt;
    upper_r    <= upper_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

@@ sv/integer_to_ascii_formatter.sv @@
// Each number passes through the idle, scan and emit states in hex modes, while decimal
// modes add a conversion state before scan that shifts the value into BCD four bits at a time.
// Throughput is one character per cycle while the consumer keeps taking characters;
// the job queue lets new numbers enter meanwhile.
// Synchronous active-low reset empties the queue and output and clears the count.
`default_nettype none

module integer_to_ascii_formatter
  import ita_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
)
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  input  ita_in_t   in_data,
  output logic      in_full,
  input  wire logic out_pop,
  output logic      out_empty,
  output ita_out_t  out_data
);

  logic     q_full;
  logic     q_push;
  logic     q_pop;
  logic     q_empty;
  ita_job_t q_job_in;
  ita_job_t q_job_out;

  // Front part: accept and classify each transaction.
  ita_front u_front (
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (q_job_in)
  );

  // Job queue between front and back.
  ita_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job_in),
    .full     (q_full),
    .pop      (q_pop),
    .head_job (q_job_out),
    .empty    (q_empty)
  );

  // Back part: convert and emit characters.
  ita_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (q_job_out),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
